/* sv/skl_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key list package
// Operation codes, cell commands and the control beat shared by the cells.
// ----------------------------------------------------------------------------
package skl_pkg;

    // Width of one stored key.
    localparam int KEY_W = 32;
    // Width of the reported position and count fields.
    localparam int POS_W = 6;
    localparam int CNT_OUT_W = 7;

    // Operation carried by one input beat.
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_DELETE = 2'd3
    } kind_t;

    // Command broadcast along the row of cells.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE
    } cell_op_t;

    // Control group driven from the sequencer into every cell.
    typedef struct packed {
        cell_op_t                 op;
        logic signed [KEY_W-1:0]  key;
    } cell_ctrl_t;

endpackage

/* sv/skl_cell.sv */
// ----------------------------------------------------------------------------
// Sorted key list cell
// Holds one key, compares it with the broadcast key and moves keys between
// neighbours on insert and delete.
// ----------------------------------------------------------------------------
module skl_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int IDX_W = 6
) (
    input  logic                            clk,
    input  skl_pkg::cell_ctrl_t             ctrl,
    input  logic [CNT_W-1:0]                count,
    input  logic [IDX_W-1:0]                del_pos,
    input  logic signed [skl_pkg::KEY_W-1:0] left_key,
    input  logic                            left_le,
    input  logic                            left_gt,
    input  logic signed [skl_pkg::KEY_W-1:0] right_key,
    output logic signed [skl_pkg::KEY_W-1:0] key_q,
    output logic                            le,
    output logic                            gt,
    output logic                            take
);
    import skl_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    valid;

    // The cell holds a live entry when its index lies below the count.
    assign valid = CNT_W'(IDX) < count;

    // Ordering flags against the broadcast key.
    assign le   = valid && (key_reg <= ctrl.key);
    assign gt   = valid && (key_reg > ctrl.key);
    // The new key lands in the first cell that is not at or below it.
    assign take = left_le && !le;

    // Next key: shift right on insert, shift left on delete, else hold.
    always_comb
    begin
        key_next = key_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (left_gt)
                begin
                    key_next = left_key;
                end
                else if (take)
                begin
                    key_next = ctrl.key;
                end
            end
            OP_DELETE:
            begin
                if (valid && (IDX_W'(IDX) >= del_pos))
                begin
                    key_next = right_key;
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    // Key storage needs no reset: dead entries are never read.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;

endmodule

/* sv/sorted_key_list_engine.sv */
// ----------------------------------------------------------------------------
// Sorted key list engine
// Ascending list of signed keys in a row of cells, with a binary search
// sequencer for search and delete.
// ----------------------------------------------------------------------------
// Clear, and insert on a full list, show the done strobe in the cycle after
// accept; insert passes through the insert state first; search makes one
// binary search probe per cycle until a hit or an empty range, and delete
// adds the delete state after a hit. The probe loop reads the cell row once
// per probe. A new beat is accepted in the cycle that the done strobe is
// shown; the receiver cannot stall. Reset empties the list.
// ----------------------------------------------------------------------------
module sorted_key_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        kind,
    input  logic signed [skl_pkg::KEY_W-1:0]  key,
    output logic                              done,
    output logic                              success,
    output logic [skl_pkg::POS_W-1:0]         position,
    output logic [skl_pkg::CNT_OUT_W-1:0]     count
);
    import skl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_SEARCH,
        S_DELETE
    } state_t;

    state_t                  state_reg, state_next;
    kind_t                   op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [IDX_W-1:0]        found_reg, found_next;
    logic                    done_reg, done_next;
    logic                    success_reg, success_next;
    logic [POS_W-1:0]        position_reg, position_next;

    cell_ctrl_t              ctrl;
    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]     cell_le;
    logic [CAPACITY-1:0]     cell_gt;
    logic [CAPACITY-1:0]     cell_take;

    logic [CNT_W:0]          mid_sum;
    logic [CNT_W-1:0]        mid;
    logic [IDX_W-1:0]        mid_idx;
    logic signed [KEY_W-1:0] probe;
    logic [IDX_W-1:0]        ins_pos;
    logic                    accept;
    logic [31:0]             count_wide;

    assign accept = start && (state_reg == S_IDLE);

    // Command for the cell row follows the sequencer state.
    always_comb
    begin
        ctrl.key = key_reg;
        unique case (state_reg)
            S_INSERT: ctrl.op = OP_INSERT;
            S_DELETE: ctrl.op = OP_DELETE;
            default:  ctrl.op = OP_HOLD;
        endcase
    end

    // Row of cells, each linked to its left and right neighbour.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] left_key;
        logic signed [KEY_W-1:0] right_key;
        logic                    left_le;
        logic                    left_gt;

        if (i == 0)
        begin : g_first
            assign left_key = '0;
            assign left_le  = 1'b1;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_inner
            assign left_key = cell_key[i-1];
            assign left_le  = cell_le[i-1];
            assign left_gt  = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = '0;
        end
        else
        begin : g_mid
            assign right_key = cell_key[i+1];
        end

        skl_cell #(
            .IDX   (i),
            .CNT_W (CNT_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .del_pos   (found_reg),
            .left_key  (left_key),
            .left_le   (left_le),
            .left_gt   (left_gt),
            .right_key (right_key),
            .key_q     (cell_key[i]),
            .le        (cell_le[i]),
            .gt        (cell_gt[i]),
            .take      (cell_take[i])
        );
    end

    // Encode the one-hot insert slot into an index.
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_take[i])
            begin
                ins_pos = ins_pos | IDX_W'(i);
            end
        end
    end

    // Binary search probe: midpoint rounded down over the half-open range.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid     = mid_sum[CNT_W:1];
    assign mid_idx = mid[IDX_W-1:0];
    assign probe   = cell_key[mid_idx];

    // Sequencer next state and result.
    always_comb
    begin
        logic [31:0] pos_wide;

        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        found_next    = found_reg;
        done_next     = 1'b0;
        success_next  = success_reg;
        position_next = position_reg;
        pos_wide      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = kind_t'(kind);
                    key_next = key;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    case (kind_t'(kind))
                        KIND_CLEAR:
                        begin
                            count_next    = '0;
                            done_next     = 1'b1;
                            success_next  = 1'b1;
                            position_next = '0;
                        end
                        KIND_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                done_next     = 1'b1;
                                success_next  = 1'b0;
                                position_next = '0;
                            end
                            else
                            begin
                                state_next = S_INSERT;
                            end
                        end
                        default:
                        begin
                            state_next = S_SEARCH;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                pos_wide      = 32'(ins_pos);
                count_next    = count_reg + 1'b1;
                done_next     = 1'b1;
                success_next  = 1'b1;
                position_next = pos_wide[POS_W-1:0];
                state_next    = S_IDLE;
            end
            S_SEARCH:
            begin
                if (lo_reg >= hi_reg)
                begin
                    done_next     = 1'b1;
                    success_next  = 1'b0;
                    position_next = '0;
                    state_next    = S_IDLE;
                end
                else if (probe == key_reg)
                begin
                    found_next = mid_idx;
                    if (op_reg == KIND_DELETE)
                    begin
                        state_next = S_DELETE;
                    end
                    else
                    begin
                        pos_wide      = 32'(mid_idx);
                        done_next     = 1'b1;
                        success_next  = 1'b1;
                        position_next = pos_wide[POS_W-1:0];
                        state_next    = S_IDLE;
                    end
                end
                else if (probe < key_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            S_DELETE:
            begin
                pos_wide      = 32'(found_reg);
                count_next    = count_reg - 1'b1;
                done_next     = 1'b1;
                success_next  = 1'b1;
                position_next = pos_wide[POS_W-1:0];
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        found_reg    <= found_next;
        success_reg  <= success_next;
        position_reg <= position_next;
    end

    // Outputs.
    assign count_wide = 32'(count_reg);
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign success    = success_reg;
    assign position   = position_reg;
    assign count      = count_wide[CNT_OUT_W-1:0];

    // The stored count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // A result follows either a busy cycle or an accepted single-cycle beat.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without a beat in progress");

    // A clear reports an empty list at position zero.
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (op_reg == KIND_CLEAR)) |-> (success && (count_reg == '0)
        && (position == '0)))
        else $error("clear result wrong");

    // A successful insert grows the list by exactly one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (op_reg == KIND_INSERT) && success)
        |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert count wrong");

endmodule
